[sv/lcs_pkg.sv]
// Package: shared types, widths and codes for the LCS length and traceback block.
package lcs_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int SYM_W       = 8;
  localparam int OP_W        = 2;
  localparam int POS_W       = 6;
  localparam int SLEN_W      = 7;
  localparam int DIR_W       = 2;

  localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

  localparam logic [DIR_W-1:0] DIR_DIAG = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] symbol;
  } in_word_t;

  typedef struct packed {
    logic [SYM_W-1:0]  out_symbol;
    logic [POS_W-1:0]  position;
    logic [SLEN_W-1:0] subsequence_length;
    logic              last;
    logic              empty_res;
    logic              overflow;
  } out_word_t;

endpackage

[sv/lcs_length_and_traceback.sv]
// Top level: LCS string loader, score/direction table fill, traceback and result emitter.
//
//   channel  ports                     handshake
//   input    start, busy, in_word      word taken at clk edge with start & !busy
//   result   out_valid, out_word       one-cycle strobe, no backpressure
//
// Append words are written while idle; busy stays low.
// Compute: table fill at one cell per cycle within a row (through the score RAM
// read/modify/write), with S_ROW_RD and S_ROW_GO between rows; each traceback step
// reads the direction RAM (S_TB_RD, then S_TB_EV); each result takes S_EM_RD, then S_EM_WR.
// Reset clears lengths, overflow flag and control; tables need no clearing.
// Results cannot be stalled; busy holds off new words until the last result.
module lcs_length_and_traceback
  import lcs_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int DIM   = MAX_LEN + 1;
  localparam int TDEP  = DIM * DIM;
  localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int AW    = (TDEP > 1) ? $clog2(TDEP) : 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ROW_RD = 8'b0000_0010,
    S_ROW_GO = 8'b0000_0100,
    S_FILL   = 8'b0000_1000,
    S_TB_RD  = 8'b0001_0000,
    S_TB_EV  = 8'b0010_0000,
    S_EM_RD  = 8'b0100_0000,
    S_EM_WR  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [LW-1:0] len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic          ovf_flag_r, ovf_flag_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [LW-1:0]    rows_r, rows_nxt, cols_r, cols_nxt;
  logic [LW-1:0]    r_r, r_nxt, kc_r, kc_nxt;
  logic [LW-1:0]    count_r, count_nxt, e_r, e_nxt;
  logic [AW-1:0]    base_r, base_nxt, addr_r, addr_nxt;
  logic [SYM_W-1:0] sym_a_r, sym_a_nxt;
  logic [LW-1:0]    diag_r, diag_nxt, left_r, left_nxt;
  logic             ovf_r, ovf_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             sa_we, sb_we, sc_we, rb_we;
  logic [IW-1:0]    sa_waddr, sb_waddr, rb_waddr;
  logic [SYM_W-1:0] sa_wdata, sb_wdata, rb_wdata;
  logic [IW-1:0]    sa_raddr, sb_raddr, rb_raddr;
  logic [SYM_W-1:0] sa_rdata, sb_rdata, rb_rdata;
  logic [AW-1:0]    sc_waddr, sc_raddr, dt_raddr;
  logic [LW-1:0]    sc_wdata, sc_rdata;
  logic [DIR_W-1:0] dt_wdata, dt_rdata;

  logic [LW-1:0]    kn, kn_m1, r_m1, rb_idx, r_new, k_new;
  logic [LW-1:0]    up_v, dg_v, lf_v, cell_v;
  logic [DIR_W-1:0] dir_v;
  logic             is_last;

  assign kn     = (state_r == S_ROW_GO) ? LW'(1) : kc_r + LW'(1);
  assign kn_m1  = kn - LW'(1);
  assign r_m1   = r_r - LW'(1);
  assign rb_idx = count_r - LW'(1) - e_r;

  assign sa_raddr = r_m1[IW-1:0];
  assign sb_raddr = kn_m1[IW-1:0];
  assign rb_raddr = rb_idx[IW-1:0];
  assign sc_raddr = base_r - AW'(DIM) + AW'(kn);
  assign sc_waddr = base_r + AW'(kc_r);
  assign dt_raddr = addr_r;

  assign up_v = (r_r == LW'(1)) ? '0 : sc_rdata;
  assign dg_v = (kc_r == LW'(1)) ? '0 : diag_r;
  assign lf_v = (kc_r == LW'(1)) ? '0 : left_r;

  always_comb begin
    if (sym_a_r == sb_rdata) begin
      cell_v = dg_v + LW'(1);
      dir_v  = DIR_DIAG;
    end else if (up_v >= lf_v) begin
      cell_v = up_v;
      dir_v  = DIR_UP;
    end else begin
      cell_v = lf_v;
      dir_v  = DIR_LEFT;
    end
  end

  assign sc_wdata = cell_v;
  assign dt_wdata = dir_v;
  assign is_last  = (count_r == '0) || (e_r + LW'(1) == count_r);

  always_comb begin
    state_nxt     = state_r;
    len_a_nxt     = len_a_r;
    len_b_nxt     = len_b_r;
    ovf_flag_nxt  = ovf_flag_r;
    out_valid_nxt = 1'b0;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    r_nxt         = r_r;
    kc_nxt        = kc_r;
    count_nxt     = count_r;
    e_nxt         = e_r;
    base_nxt      = base_r;
    addr_nxt      = addr_r;
    sym_a_nxt     = sym_a_r;
    diag_nxt      = diag_r;
    left_nxt      = left_r;
    ovf_nxt       = ovf_r;
    out_word_nxt  = out_word_r;
    r_new         = r_r;
    k_new         = kc_r;
    sa_we         = 1'b0;
    sb_we         = 1'b0;
    sc_we         = 1'b0;
    rb_we         = 1'b0;
    sa_waddr      = len_a_r[IW-1:0];
    sb_waddr      = len_b_r[IW-1:0];
    rb_waddr      = count_r[IW-1:0];
    sa_wdata      = in_word.symbol;
    sb_wdata      = in_word.symbol;
    rb_wdata      = sa_rdata;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_word.op)
            OP_APPEND_A: begin
              if (len_a_r < LW'(MAX_LEN)) begin
                sa_we     = 1'b1;
                len_a_nxt = len_a_r + LW'(1);
              end else begin
                ovf_flag_nxt = 1'b1;
              end
            end
            OP_APPEND_B: begin
              if (len_b_r < LW'(MAX_LEN)) begin
                sb_we     = 1'b1;
                len_b_nxt = len_b_r + LW'(1);
              end else begin
                ovf_flag_nxt = 1'b1;
              end
            end
            OP_COMPUTE: begin
              rows_nxt     = len_a_r;
              cols_nxt     = len_b_r;
              ovf_nxt      = ovf_flag_r;
              len_a_nxt    = '0;
              len_b_nxt    = '0;
              ovf_flag_nxt = 1'b0;
              r_nxt        = LW'(1);
              base_nxt     = AW'(DIM);
              count_nxt    = '0;
              e_nxt        = '0;
              if (len_a_r == '0 || len_b_r == '0) begin
                state_nxt = S_EM_RD;
              end else begin
                state_nxt = S_ROW_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ROW_RD: begin
        state_nxt = S_ROW_GO;
      end
      S_ROW_GO: begin
        sym_a_nxt = sa_rdata;
        kc_nxt    = LW'(1);
        state_nxt = S_FILL;
      end
      S_FILL: begin
        sc_we    = 1'b1;
        diag_nxt = up_v;
        left_nxt = cell_v;
        if (kc_r == cols_r) begin
          if (r_r == rows_r) begin
            addr_nxt  = base_r + AW'(kc_r);
            count_nxt = '0;
            state_nxt = S_TB_RD;
          end else begin
            r_nxt     = r_r + LW'(1);
            base_nxt  = base_r + AW'(DIM);
            state_nxt = S_ROW_RD;
          end
        end else begin
          kc_nxt = kn;
        end
      end
      S_TB_RD: begin
        state_nxt = S_TB_EV;
      end
      S_TB_EV: begin
        case (dt_rdata)
          DIR_DIAG: begin
            if (count_r < LW'(MAX_LEN)) begin
              rb_we     = 1'b1;
              count_nxt = count_r + LW'(1);
            end
            r_new    = r_r - LW'(1);
            k_new    = kc_r - LW'(1);
            addr_nxt = addr_r - AW'(DIM + 1);
          end
          DIR_UP: begin
            r_new    = r_r - LW'(1);
            addr_nxt = addr_r - AW'(DIM);
          end
          default: begin
            k_new    = kc_r - LW'(1);
            addr_nxt = addr_r - AW'(1);
          end
        endcase
        r_nxt  = r_new;
        kc_nxt = k_new;
        if (r_new == '0 || k_new == '0) begin
          e_nxt     = '0;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_TB_RD;
        end
      end
      S_EM_RD: begin
        state_nxt = S_EM_WR;
      end
      S_EM_WR: begin
        out_valid_nxt                   = 1'b1;
        out_word_nxt.overflow           = ovf_r;
        out_word_nxt.last               = is_last;
        out_word_nxt.subsequence_length = SLEN_W'(count_r);
        if (count_r == '0) begin
          out_word_nxt.out_symbol = '0;
          out_word_nxt.position   = '0;
          out_word_nxt.empty_res  = 1'b1;
        end else begin
          out_word_nxt.out_symbol = rb_rdata;
          out_word_nxt.position   = POS_W'(e_r);
          out_word_nxt.empty_res  = 1'b0;
        end
        if (is_last) begin
          state_nxt = S_IDLE;
        end else begin
          e_nxt     = e_r + LW'(1);
          state_nxt = S_EM_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_a_r     <= '0;
      len_b_r     <= '0;
      ovf_flag_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      ovf_flag_r  <= ovf_flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rows_r     <= rows_nxt;
    cols_r     <= cols_nxt;
    r_r        <= r_nxt;
    kc_r       <= kc_nxt;
    count_r    <= count_nxt;
    e_r        <= e_nxt;
    base_r     <= base_nxt;
    addr_r     <= addr_nxt;
    sym_a_r    <= sym_a_nxt;
    diag_r     <= diag_nxt;
    left_r     <= left_nxt;
    ovf_r      <= ovf_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_str_a (
    .clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(sa_wdata),
    .raddr(sa_raddr), .rdata(sa_rdata)
  );

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_str_b (
    .clk(clk), .we(sb_we), .waddr(sb_waddr), .wdata(sb_wdata),
    .raddr(sb_raddr), .rdata(sb_rdata)
  );

  lcs_ram #(.WIDTH(LW), .DEPTH(TDEP)) u_score (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
    .raddr(sc_raddr), .rdata(sc_rdata)
  );

  lcs_ram #(.WIDTH(DIR_W), .DEPTH(TDEP)) u_dir (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(dt_wdata),
    .raddr(dt_raddr), .rdata(dt_rdata)
  );

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_result (
    .clk(clk), .we(rb_we), .waddr(rb_waddr), .wdata(rb_wdata),
    .raddr(rb_raddr), .rdata(rb_rdata)
  );

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> kc_r >= LW'(1) && kc_r <= cols_r && r_r <= rows_r)
    else $error("fill column out of range");

  a_tb_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TB_EV |-> count_r <= rows_r && count_r <= cols_r)
    else $error("traceback count exceeds table size");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EM_WR))
    else $error("result strobe without emit step");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |-> !busy)
    else $error("still busy after last result");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.empty_res |-> out_word.last && out_word.subsequence_length == '0)
    else $error("malformed empty result");

endmodule

[sv/lcs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
